// ===== hdl/bafr_pkg.sv =====
// ----------------------------------------------------------------------------
// bafr_pkg: shared types and constants of the bump allocator with free ring
// request codes, controller states, command and status bundles, defaults
// ----------------------------------------------------------------------------
`default_nettype none

package bafr_pkg;

  // default sizes
  localparam int unsigned NUM_POOLS_DEF = 4;
  localparam longint unsigned REGION_BYTES_DEF = 64'd1073741824;
  localparam int unsigned ADDR_BITS_DEF = 48;

  // fixed field and storage widths
  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned SLOT_BITS = 8;
  localparam int unsigned OFFSET_BITS = 40;
  localparam int unsigned KIND_BITS = 3;
  localparam int unsigned POOL_IN_BITS = 2;
  localparam int unsigned SIZE_BITS = 32;
  localparam int unsigned ALIGN_BITS = 32;
  localparam int unsigned PORT_ADDR_BITS = 48;

  // reuse only when more than this many blocks are queued
  localparam logic [SLOT_BITS-1:0] REUSE_MIN = 8'd2;

  // request codes
  typedef enum logic [KIND_BITS-1:0] {
    REQ_ALLOC    = 3'd0,
    REQ_ALIGNED  = 3'd1,
    REQ_FREE     = 3'd2,
    REQ_SET_BASE = 3'd3,
    REQ_ADV_BASE = 3'd4
  } req_kind_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_REUSE,
    S_ADDR,
    S_PAD,
    S_APPLY,
    S_BUMP,
    S_RESULT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic set_base;
    logic adv_base;
    logic free_push;
    logic reuse_pop;
    logic form_addr;
    logic calc_pad;
    logic apply_pad;
    logic bump;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic                 pool_ok;
    logic                 reuse_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/bafr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bafr_ctrl: request sequencer
// steps the datapath through the phases of one request and marks the result
// ----------------------------------------------------------------------------
`default_nettype none

module bafr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  bafr_pkg::dp_status_t      status,
  output bafr_pkg::dp_cmd_t         cmd,
  output logic                      busy,
  output logic                      done
);

  bafr_pkg::ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bafr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      bafr_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = bafr_pkg::S_DECODE;
        end
      end
      bafr_pkg::S_DECODE: begin
        state_next = bafr_pkg::S_RESULT;
        if (status.pool_ok) begin
          case (status.kind)
            bafr_pkg::REQ_ALLOC: begin
              if (status.reuse_ok) begin
                state_next = bafr_pkg::S_REUSE;
              end else begin
                state_next = bafr_pkg::S_ADDR;
              end
            end
            bafr_pkg::REQ_ALIGNED:  state_next = bafr_pkg::S_ADDR;
            bafr_pkg::REQ_FREE:     cmd.free_push = 1'b1;
            bafr_pkg::REQ_SET_BASE: cmd.set_base = 1'b1;
            bafr_pkg::REQ_ADV_BASE: cmd.adv_base = 1'b1;
            default:                state_next = bafr_pkg::S_RESULT;
          endcase
        end
      end
      bafr_pkg::S_REUSE: begin
        cmd.reuse_pop = 1'b1;
        state_next    = bafr_pkg::S_RESULT;
      end
      bafr_pkg::S_ADDR: begin
        cmd.form_addr = 1'b1;
        if (status.kind == bafr_pkg::REQ_ALIGNED) begin
          state_next = bafr_pkg::S_PAD;
        end else begin
          state_next = bafr_pkg::S_BUMP;
        end
      end
      bafr_pkg::S_PAD: begin
        cmd.calc_pad = 1'b1;
        state_next   = bafr_pkg::S_APPLY;
      end
      bafr_pkg::S_APPLY: begin
        cmd.apply_pad = 1'b1;
        state_next    = bafr_pkg::S_BUMP;
      end
      bafr_pkg::S_BUMP: begin
        cmd.bump   = 1'b1;
        state_next = bafr_pkg::S_RESULT;
      end
      bafr_pkg::S_RESULT: begin
        done       = 1'b1;
        state_next = bafr_pkg::S_IDLE;
      end
      default: begin
        state_next = bafr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/bafr_datapath.sv =====
// ----------------------------------------------------------------------------
// bafr_datapath: pool state, free ring memory and address arithmetic
// holds per-pool base, offset and ring pointers, and the result registers
// ----------------------------------------------------------------------------
`default_nettype none

module bafr_datapath #(
  parameter int unsigned      NUM_POOLS    = bafr_pkg::NUM_POOLS_DEF,
  parameter longint unsigned  REGION_BYTES = bafr_pkg::REGION_BYTES_DEF,
  parameter int unsigned      ADDR_BITS    = bafr_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  bafr_pkg::dp_cmd_t                           cmd,
  output bafr_pkg::dp_status_t                        status,
  input  wire logic [bafr_pkg::KIND_BITS-1:0]         req_type,
  input  wire logic [bafr_pkg::POOL_IN_BITS-1:0]      pool_index,
  input  wire logic [bafr_pkg::SIZE_BITS-1:0]         byte_count,
  input  wire logic [bafr_pkg::ALIGN_BITS-1:0]        align_bytes,
  input  wire logic [bafr_pkg::PORT_ADDR_BITS-1:0]    given_address,
  output logic      [bafr_pkg::PORT_ADDR_BITS-1:0]    block_address,
  output logic                                        reused_block,
  output logic                                        out_of_bounds
);

  localparam int unsigned POOL_BITS = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned MEM_DEPTH = NUM_POOLS * bafr_pkg::RING_DEPTH;
  localparam int unsigned MEM_ABITS = POOL_BITS + bafr_pkg::SLOT_BITS;
  localparam logic [bafr_pkg::OFFSET_BITS-1:0] REGION_LIMIT =
    bafr_pkg::OFFSET_BITS'(REGION_BYTES);

  // latched request
  logic [bafr_pkg::KIND_BITS-1:0]      req_kind;
  logic [bafr_pkg::POOL_IN_BITS-1:0]   req_pool;
  logic [bafr_pkg::SIZE_BITS-1:0]      req_size;
  logic [bafr_pkg::ALIGN_BITS-1:0]     req_align;
  logic [bafr_pkg::PORT_ADDR_BITS-1:0] req_addr;

  // per-pool state
  logic [ADDR_BITS-1:0]             region_base    [NUM_POOLS];
  logic [bafr_pkg::OFFSET_BITS-1:0] bump_offset    [NUM_POOLS];
  logic [bafr_pkg::SLOT_BITS-1:0]   ring_write_pos [NUM_POOLS];
  logic [bafr_pkg::SLOT_BITS-1:0]   ring_count     [NUM_POOLS];

  // free ring storage, all pools in one memory
  logic [ADDR_BITS-1:0] free_ring [MEM_DEPTH];

  // result and scratch registers
  logic [ADDR_BITS-1:0]            res_addr;
  logic                            res_reused;
  logic                            res_oob;
  logic [bafr_pkg::ALIGN_BITS-1:0] pad_amt;

  logic [4:0]                       pool_wide;
  logic [POOL_BITS-1:0]             pool_sel;
  logic [ADDR_BITS-1:0]             cur_base;
  logic [bafr_pkg::OFFSET_BITS-1:0] cur_off;
  logic [bafr_pkg::SLOT_BITS-1:0]   cur_wpos;
  logic [bafr_pkg::SLOT_BITS-1:0]   cur_cnt;
  logic [bafr_pkg::SLOT_BITS-1:0]   rd_slot;
  logic [bafr_pkg::ALIGN_BITS-1:0]  align_mask;
  logic [bafr_pkg::ALIGN_BITS-1:0]  addr_low;
  logic [bafr_pkg::OFFSET_BITS-1:0] off_sum;

  // pool selection and current pool values
  always_comb begin
    pool_wide  = 5'(req_pool);
    pool_sel   = pool_wide[POOL_BITS-1:0];
    cur_base   = region_base[pool_sel];
    cur_off    = bump_offset[pool_sel];
    cur_wpos   = ring_write_pos[pool_sel];
    cur_cnt    = ring_count[pool_sel];
    rd_slot    = cur_wpos - cur_cnt;
    align_mask = (req_align == '0) ? '0 : (req_align - 1'b1);
    addr_low   = res_addr[bafr_pkg::ALIGN_BITS-1:0] & align_mask;
    off_sum    = cur_off + bafr_pkg::OFFSET_BITS'(req_size);
  end

  // status toward the controller
  assign status.kind     = req_kind;
  assign status.pool_ok  = (pool_wide < 5'(NUM_POOLS));
  assign status.reuse_ok = (cur_cnt > bafr_pkg::REUSE_MIN);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= req_type;
      req_pool  <= pool_index;
      req_size  <= byte_count;
      req_align <= align_bytes;
      req_addr  <= given_address;
    end
  end

  // pool state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        region_base[i]    <= '0;
        bump_offset[i]    <= '0;
        ring_write_pos[i] <= '0;
        ring_count[i]     <= '0;
      end
    end else begin
      if (cmd.set_base) begin
        region_base[pool_sel] <= ADDR_BITS'(req_addr);
      end
      if (cmd.adv_base) begin
        region_base[pool_sel] <= cur_base + ADDR_BITS'(req_size);
      end
      if (cmd.free_push) begin
        ring_write_pos[pool_sel] <= cur_wpos + 1'b1;
        ring_count[pool_sel]     <= cur_cnt + 1'b1;
      end
      if (cmd.reuse_pop) begin
        ring_count[pool_sel] <= cur_cnt - 1'b1;
      end
      if (cmd.apply_pad) begin
        bump_offset[pool_sel] <= cur_off + bafr_pkg::OFFSET_BITS'(pad_amt);
      end
      if (cmd.bump) begin
        bump_offset[pool_sel] <= off_sum;
      end
    end
  end

  // free ring write port
  always_ff @(posedge clk) begin
    if (cmd.free_push) begin
      free_ring[{pool_sel, cur_wpos}] <= ADDR_BITS'(req_addr);
    end
  end

  // result registers; ring read lands directly in the address register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_addr   <= '0;
      res_reused <= 1'b0;
      res_oob    <= 1'b0;
    end
    if (cmd.reuse_pop) begin
      res_addr   <= free_ring[MEM_ABITS'({pool_sel, rd_slot})];
      res_reused <= 1'b1;
    end
    if (cmd.form_addr) begin
      res_addr <= cur_base + ADDR_BITS'(cur_off);
    end
    if (cmd.calc_pad) begin
      pad_amt <= (addr_low != '0) ? (req_align - addr_low) : '0;
    end
    if (cmd.apply_pad) begin
      res_addr <= res_addr + ADDR_BITS'(pad_amt);
    end
    if (cmd.bump) begin
      res_oob <= (off_sum > REGION_LIMIT);
    end
  end

  // result ports
  assign block_address = bafr_pkg::PORT_ADDR_BITS'(res_addr);
  assign reused_block  = res_reused;
  assign out_of_bounds = res_oob;

endmodule

`default_nettype wire

// ===== hdl/bump_allocator_with_free_ring.sv =====
// ----------------------------------------------------------------------------
// bump_allocator_with_free_ring: region allocator with per-pool free rings
// each request takes one pool; allocations reuse queued blocks or bump
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; busy stays high
// until its single result has been shown. The result appears on
// block_address, reused_block and out_of_bounds for exactly one cycle with
// done high, and must be taken in that cycle: there is no way to hold it.
// The sequencer runs each request from decode to the result state: free,
// base requests, unused codes and absent pools go there directly, a free
// ring allocation through reuse (one registered ring memory read), a bump
// allocation through address and bump, an aligned one through address,
// pad, apply and bump. The next request can be taken in the cycle after
// done. The free ring is not cleared after reset; allocation from it
// needs entries freed beforehand.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_allocator_with_free_ring #(
  parameter int unsigned      NUM_POOLS    = bafr_pkg::NUM_POOLS_DEF,
  parameter longint unsigned  REGION_BYTES = bafr_pkg::REGION_BYTES_DEF,
  parameter int unsigned      ADDR_BITS    = bafr_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [bafr_pkg::KIND_BITS-1:0]      req_type,
  input  wire logic [bafr_pkg::POOL_IN_BITS-1:0]   pool_index,
  input  wire logic [bafr_pkg::SIZE_BITS-1:0]      byte_count,
  input  wire logic [bafr_pkg::ALIGN_BITS-1:0]     align_bytes,
  input  wire logic [bafr_pkg::PORT_ADDR_BITS-1:0] given_address,
  output logic                                     done,
  output logic      [bafr_pkg::PORT_ADDR_BITS-1:0] block_address,
  output logic                                     reused_block,
  output logic                                     out_of_bounds
);

  bafr_pkg::dp_cmd_t    cmd;
  bafr_pkg::dp_status_t status;

  // sequencer
  bafr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // pool state and arithmetic
  bafr_datapath #(
    .NUM_POOLS    (NUM_POOLS),
    .REGION_BYTES (REGION_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (req_type),
    .pool_index    (pool_index),
    .byte_count    (byte_count),
    .align_bytes   (align_bytes),
    .given_address (given_address),
    .block_address (block_address),
    .reused_block  (reused_block),
    .out_of_bounds (out_of_bounds)
  );

endmodule

`default_nettype wire
